/* hdl/duty_command_packet_framer_assert.svh */
// Assertion macros shared by the duty command packet framer modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef DUTY_COMMAND_PACKET_FRAMER_ASSERT_SVH
`define DUTY_COMMAND_PACKET_FRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define DCPF_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcpf: implication check failed");
// Next-cycle implication
`define DCPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcpf: next-cycle check failed");
`else
`define DCPF_ASSERT_IMPLIES(label, ante, cons)
`define DCPF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/dcpf_pkg.sv */
// Package for the duty command packet framer: framing constants and the
// command descriptor passed from the front end to the byte sequencer.
// No dependencies.
package dcpf_pkg;

  // Framing bytes
  localparam logic [7:0] FRAME_START = 8'h02;
  localparam logic [7:0] FRAME_STOP  = 8'h03;

  // Payload command codes and lengths
  localparam logic [7:0] CMD_DUTY    = 8'd5;
  localparam logic [7:0] CMD_FORWARD = 8'd34;
  localparam logic [7:0] LEN_DIRECT  = 8'd5;
  localparam logic [7:0] LEN_FORWARD = 8'd7;

  // CRC-16/XMODEM polynomial
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Duty scale: raw = duty * 100000 / 65536
  localparam logic [16:0] DUTY_SCALE = 17'd100000;

  // Packet kinds
  localparam logic OP_DIRECT  = 1'b0;
  localparam logic OP_FORWARD = 1'b1;

  // Classified command waiting for the sequencer
  typedef struct packed {
    logic        op;
    logic [7:0]  target_id;
    logic [31:0] word;
  } dcpf_desc_t;

endpackage

/* hdl/dcpf_front.sv */
// Front end: accepts a duty command, scales the duty to a raw count and
// pushes a descriptor into the queue. Depends on dcpf_pkg.
module dcpf_front import dcpf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [7:0]         target_id,
  input  logic signed [17:0] duty_fraction,
  output logic               push_valid,
  input  logic               push_stall,
  output dcpf_desc_t         push_desc
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]  state;
  logic        op_r;
  logic [7:0]  tid_r;
  logic        neg;
  logic [17:0] mag;
  logic [34:0] prod;
  logic [17:0] mag_in;
  logic [31:0] q_ext;

  // Magnitude of the incoming duty; -131072 maps to 131072, which fits 18 bits
  assign mag_in = duty_fraction[17] ? (18'd0 - duty_fraction) : duty_fraction;

  assign in_stall = (state != S_IDLE);

  // Truncated quotient, then signed word
  assign q_ext               = {14'd0, prod[33:16]};
  assign push_valid          = (state == S_PUSH);
  assign push_desc.op        = op_r;
  assign push_desc.target_id = tid_r;
  assign push_desc.word      = neg ? (32'd0 - q_ext) : q_ext;

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r  <= op;
      tid_r <= target_id;
      neg   <= duty_fraction[17];
      mag   <= mag_in;
    end
    if (state == S_MUL) begin
      prod <= mag * DUTY_SCALE;
    end
  end

  // Control sequence: accept, multiply, push
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_MUL;
        S_MUL:  state <= S_PUSH;
        S_PUSH: if (!push_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/dcpf_queue.sv */
// Small descriptor queue between the front end and the byte sequencer.
// Depends on dcpf_pkg.
`include "duty_command_packet_framer_assert.svh"
module dcpf_queue import dcpf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_stall,
  input  dcpf_desc_t push_desc,
  output logic       pop_valid,
  input  logic       pop_stall,
  output dcpf_desc_t pop_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  dcpf_desc_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_stall = (count == FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_desc   = entries[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `DCPF_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1)
  `DCPF_ASSERT_IMPLIES(a_count_range, pop_valid, count <= FULL_CNT)

endmodule

/* hdl/dcpf_back.sv */
// Back end: walks one descriptor through the framed packet, one byte per
// cycle into an output register unless stalled, with a running CRC-16. Depends on dcpf_pkg.
`include "duty_command_packet_framer_assert.svh"
module dcpf_back import dcpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_stall,
  input  dcpf_desc_t pop_desc,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last
);

  // Byte positions of the forwarded layout; direct packets skip FWD and TID
  localparam logic [3:0] POS_START = 4'd0;
  localparam logic [3:0] POS_LEN   = 4'd1;
  localparam logic [3:0] POS_FWD   = 4'd2;
  localparam logic [3:0] POS_TID   = 4'd3;
  localparam logic [3:0] POS_CMD   = 4'd4;
  localparam logic [3:0] POS_W3    = 4'd5;
  localparam logic [3:0] POS_W2    = 4'd6;
  localparam logic [3:0] POS_W1    = 4'd7;
  localparam logic [3:0] POS_W0    = 4'd8;
  localparam logic [3:0] POS_CRCH  = 4'd9;
  localparam logic [3:0] POS_CRCL  = 4'd10;
  localparam logic [3:0] POS_STOP  = 4'd11;

  logic        busy;
  logic        op_r;
  logic [7:0]  tid_r;
  logic [31:0] word_r;
  logic [3:0]  pos;
  logic [15:0] crc;
  logic [7:0]  cur_byte;
  logic        is_payload;
  logic        advance;
  logic [3:0]  pos_next;
  logic [15:0] crc_next;

  // One byte of CRC-16/XMODEM, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  assign advance   = !out_valid || !out_stall;
  assign pop_stall = busy;

  // Byte select for the current position
  always_comb begin
    case (pos)
      POS_START: cur_byte = FRAME_START;
      POS_LEN:   cur_byte = op_r ? LEN_FORWARD : LEN_DIRECT;
      POS_FWD:   cur_byte = CMD_FORWARD;
      POS_TID:   cur_byte = tid_r;
      POS_CMD:   cur_byte = CMD_DUTY;
      POS_W3:    cur_byte = word_r[31:24];
      POS_W2:    cur_byte = word_r[23:16];
      POS_W1:    cur_byte = word_r[15:8];
      POS_W0:    cur_byte = word_r[7:0];
      POS_CRCH:  cur_byte = crc[15:8];
      POS_CRCL:  cur_byte = crc[7:0];
      POS_STOP:  cur_byte = FRAME_STOP;
      default:   cur_byte = FRAME_STOP;
    endcase
  end

  assign is_payload = (pos inside {[POS_FWD:POS_W0]});
  assign crc_next   = is_payload ? crc_feed(crc, cur_byte) : crc;
  assign pos_next   = (pos == POS_LEN && op_r == OP_DIRECT) ? POS_CMD : pos + 4'd1;

  // Descriptor and CRC registers
  always_ff @(posedge clk) begin
    if (!busy && pop_valid) begin
      op_r   <= pop_desc.op;
      tid_r  <= pop_desc.target_id;
      word_r <= pop_desc.word;
      crc    <= '0;
    end else if (busy && advance) begin
      crc <= crc_next;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (busy && advance) begin
      out_byte <= cur_byte;
      last     <= (pos == POS_STOP);
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= POS_START;
      out_valid <= 1'b0;
    end else begin
      if (!busy) begin
        if (pop_valid) begin
          busy <= 1'b1;
          pos  <= POS_START;
        end
      end else if (advance) begin
        pos <= pos_next;
        if (pos == POS_STOP) busy <= 1'b0;
      end
      if (advance) out_valid <= busy;
    end
  end

  `DCPF_ASSERT_IMPLIES(a_last_is_stop, out_valid && last, out_byte == FRAME_STOP)
  `DCPF_ASSERT_IMPLIES(a_direct_skips, busy && op_r == OP_DIRECT, pos != POS_FWD && pos != POS_TID)
  `DCPF_ASSERT_NEXT(a_stop_frees, busy && advance && pos == POS_STOP, !busy && out_valid && last)

endmodule

/* hdl/duty_command_packet_framer.sv */
// Duty command packet framer, top level.
// Input channel (in_valid/in_stall): one duty command per transaction with
// op (0 direct, 1 forwarded), target_id and duty_fraction (signed
// Q1.16). Output channel (out_valid/out_stall): one byte of the framed
// packet per transaction, last set on the stop byte 0x03.
// A packet is 0x02, length, payload, CRC-16/XMODEM of the payload (high
// byte first), 0x03: 10 bytes for a direct command, 12 for a forwarded one.
// The front end accepts a command, multiplies and pushes the descriptor into
// the queue; the sequencer then loads it and registers the first byte into
// the output. Bytes follow at one per cycle while the output is not stalled.
// The sequencer takes no new descriptor until it has registered the stop
// byte of its packet, and it loads each descriptor before its first byte.
// Behind the packet being sent, up to QUEUE_DEPTH commands wait in the
// queue and one more waits in the front end.
// Reset clears the queue, the sequencer and the output valid; a packet in
// flight is dropped. A stalled output holds its byte; the sequencer waits,
// the queue fills and then the input stalls.
// Depends on dcpf_pkg, dcpf_front, dcpf_queue and dcpf_back.
module duty_command_packet_framer import dcpf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [7:0]         target_id,
  input  logic signed [17:0] duty_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               last
);

  logic       push_valid;
  logic       push_stall;
  dcpf_desc_t push_desc;
  logic       pop_valid;
  logic       pop_stall;
  dcpf_desc_t pop_desc;

  dcpf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .target_id     (target_id),
    .duty_fraction (duty_fraction),
    .push_valid    (push_valid),
    .push_stall    (push_stall),
    .push_desc     (push_desc)
  );

  dcpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_desc   (pop_desc)
  );

  dcpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_desc  (pop_desc),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

/* bench/duty_command_packet_framer_tb.sv */
// Self-checking testbench for duty_command_packet_framer: directed commands
// from a table, then random commands, with every output byte checked.
// Depends on dcpf_pkg and the duty_command_packet_framer RTL.
module duty_command_packet_framer_tb import dcpf_pkg::*;;

  localparam int N_DIRECTED     = 16;
  localparam int N_RANDOM       = 304;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;

  // One expected output byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // One directed command; pinned rows carry the raw count typed in by hand
  typedef struct packed {
    logic        op;
    logic [7:0]  tid;
    logic [17:0] duty;
    logic        pinned;
    logic [31:0] count;
  } cmd_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [7:0]         target_id = 8'h00;
  logic signed [17:0] duty_fraction = 18'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               last;

  frame_byte_t packet_bytes_due[$];
  frame_byte_t next_due;
  int          errors = 0;
  int          quiet_cycles = 0;
  logic        no_idle = 1'b0;
  logic        hold_req = 1'b0;

  cmd_row_t directed [N_DIRECTED] = '{
    '{OP_DIRECT,  8'h00, 18'h00000, 1'b1, 32'h00000000},
    '{OP_FORWARD, 8'h00, 18'h00000, 1'b1, 32'h00000000},
    '{OP_DIRECT,  8'hFF, 18'h10000, 1'b1, 32'h000186A0},
    '{OP_FORWARD, 8'hFF, 18'h10000, 1'b1, 32'h000186A0},
    '{OP_DIRECT,  8'h5A, 18'h30000, 1'b1, 32'hFFFE7960},
    '{OP_FORWARD, 8'hA5, 18'h30000, 1'b1, 32'hFFFE7960},
    '{OP_DIRECT,  8'h00, 18'h1FFFF, 1'b1, 32'h00030D3E},
    '{OP_FORWARD, 8'hFF, 18'h1FFFF, 1'b1, 32'h00030D3E},
    '{OP_DIRECT,  8'hFF, 18'h20000, 1'b1, 32'hFFFCF2C0},
    '{OP_FORWARD, 8'h00, 18'h20000, 1'b1, 32'hFFFCF2C0},
    '{OP_DIRECT,  8'h3C, 18'h00001, 1'b1, 32'h00000001},
    '{OP_FORWARD, 8'hC3, 18'h3FFFF, 1'b1, 32'hFFFFFFFF},
    '{OP_DIRECT,  8'h00, 18'h08000, 1'b1, 32'h0000C350},
    '{OP_FORWARD, 8'h7E, 18'h0ABCD, 1'b0, 32'h00000000},
    '{OP_DIRECT,  8'h81, 18'h2F0F1, 1'b0, 32'h00000000},
    '{OP_FORWARD, 8'h01, 18'h15555, 1'b0, 32'h00000000}
  };

  duty_command_packet_framer u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .target_id     (target_id),
    .duty_fraction (duty_fraction),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last          (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Q1.16 duty to raw count: duty * 100000 / 65536, truncated toward zero
  function automatic logic [31:0] duty_to_count(logic [17:0] duty);
    logic [17:0] mag;
    logic [35:0] prod;
    logic [31:0] q;
    mag  = duty[17] ? (18'd0 - duty) : duty;
    prod = {18'd0, mag} * 36'd100000;
    q    = 32'(prod >> 16);
    return duty[17] ? (32'd0 - q) : q;
  endfunction

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Queue the bytes of the packet framed around one raw count
  task automatic frame_command(input logic kind, input logic [7:0] tid,
                               input logic [31:0] count);
    logic [7:0]  payload [7];
    int          plen;
    logic [15:0] crc;
    plen = 0;
    crc  = 16'h0000;
    if (kind == OP_FORWARD) begin
      payload[0] = CMD_FORWARD;
      payload[1] = tid;
      plen = 2;
    end
    payload[plen]     = CMD_DUTY;
    payload[plen + 1] = count[31:24];
    payload[plen + 2] = count[23:16];
    payload[plen + 3] = count[15:8];
    payload[plen + 4] = count[7:0];
    plen += 5;
    packet_bytes_due.push_back(frame_byte_t'{FRAME_START, 1'b0});
    packet_bytes_due.push_back(frame_byte_t'{8'(plen), 1'b0});
    for (int i = 0; i < plen; i++) begin
      crc = crc16_feed(crc, payload[i]);
      packet_bytes_due.push_back(frame_byte_t'{payload[i], 1'b0});
    end
    packet_bytes_due.push_back(frame_byte_t'{crc[15:8], 1'b0});
    packet_bytes_due.push_back(frame_byte_t'{crc[7:0], 1'b0});
    packet_bytes_due.push_back(frame_byte_t'{FRAME_STOP, 1'b1});
  endtask

  // Offer one command after a random gap; queue its packet once accepted
  task automatic send_command(input logic kind, input logic [7:0] tid,
                              input logic [17:0] duty, input logic pinned,
                              input logic [31:0] count);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= kind;
    target_id     <= tid;
    duty_fraction <= duty;
    do @(posedge clk); while (in_stall);
    frame_command(kind, tid, pinned ? count : duty_to_count(duty));
  endtask

  // Random duty: mostly nominal range, some full 18-bit, some near the extremes
  function automatic logic [17:0] random_duty();
    int pick;
    int off;
    pick = $urandom_range(0, 9);
    off  = $urandom_range(0, 15);
    if (pick < 6) return 18'($urandom_range(0, 131072) - 65536);
    if (pick < 8) return 18'($urandom);
    case ($urandom_range(0, 3))
      0:       return 18'h10000 - 18'(off);
      1:       return 18'h30000 + 18'(off);
      2:       return 18'h1FFFF - 18'(off);
      default: return 18'h20000 + 18'(off);
    endcase
  endfunction

  // Output side: random stall per byte, one long hold on request
  initial begin : byte_sink
    int hold;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each output transaction with the oldest expected byte
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (packet_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual %h last %b",
                 $time, out_byte, last);
      end else begin
        next_due = packet_bytes_due.pop_front();
        if (out_byte !== next_due.data) begin
          errors++;
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, next_due.data, out_byte);
        end
        if (last !== next_due.last) begin
          errors++;
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, next_due.last, last);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("duty_command_packet_framer_tb NOT OK");
      $finish;
    end
  end

  // Main sequence
  initial begin : stimulus
    logic        kind;
    logic [7:0]  tid;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed[i]) begin
      send_command(directed[i].op, directed[i].tid, directed[i].duty,
                   directed[i].pinned, directed[i].count);
    end

    // Random commands; a back-to-back stretch carries the long output hold
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 120) no_idle = 1'b1;
      if (i == 140) hold_req = 1'b1;
      if (i == 200) no_idle = 1'b0;
      kind = 1'($urandom_range(0, 1));
      tid  = 8'($urandom_range(0, 255));
      send_command(kind, tid, random_duty(), 1'b0, 32'h0);
    end
    in_valid <= 1'b0;

    // Drain, then a short tail for stray bytes
    while (packet_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("duty_command_packet_framer_tb OK");
    else
      $display("duty_command_packet_framer_tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/dcpf_pkg.sv
hdl/dcpf_front.sv
hdl/dcpf_queue.sv
hdl/dcpf_back.sv
hdl/duty_command_packet_framer.sv
bench/duty_command_packet_framer_tb.sv
